// ===== hdl/link_sequence_checker_assert.svh =====
// Assertion macros shared by the link checker RTL.
`ifndef LINK_SEQUENCE_CHECKER_ASSERT_SVH
`define LINK_SEQUENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("link_sequence_checker: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("link_sequence_checker: next-cycle check failed");

`endif

// ===== hdl/lsc_pkg.sv =====
package lsc_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TOLERANT_MODE  = 2'd0,
    REG_VERIFY_PAYLOAD = 2'd1,
    REG_STOP_ON_ERROR  = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/link_sequence_checker.sv =====
// Link sequence checker: checks received link-test frames one byte at a time.
// Byte channel (byte_valid / byte_stall): data_byte with frame_start and
// frame_end marks; a request is taken when byte_valid is high and byte_stall
// is low. Status channel (status_valid / status_stall): one status request
// per frame, issued for the byte carrying frame_end of an open frame.
// Configuration: cfg_write with cfg_index and cfg_data sets tolerant_mode,
// verify_payload and stop_on_error; write only while no frame is in flight.
// Path: a taken frame_end byte goes to the byte register, then its status to
// the status register. Throughput: one byte per cycle unless a status is held
// stalled, set by the single byte register feeding the frame state update.
// Stall: the status register holds while status_stall is high; the byte
// register still takes one more byte, then byte_stall rises until the
// status request is taken.
// Reset (rst, synchronous, active high): clears the configuration, the
// expectation and its seeded flag, all per-frame state and the sticky
// failure flag, and empties both registers.
module link_sequence_checker
  import lsc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_data,
  // byte channel
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              frame_start,
  input  logic              frame_end,
  // status channel
  output logic              status_valid,
  input  logic              status_stall,
  output logic              seq_mismatch,
  output logic              payload_mismatch,
  output logic [BYTE_W-1:0] expected_seq,
  output logic [BYTE_W-1:0] got_seq,
  output logic [POS_W-1:0]  bad_position,
  output logic              failed
);

  `include "link_sequence_checker_assert.svh"

  localparam logic [POS_W:0] MAX_POS = (POS_W + 1)'(MAX_FRAME_BYTES);

  // configuration
  logic tolerant_mode;
  logic verify_payload;
  logic stop_on_error;

  // byte register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_data;
  logic              s1_start;
  logic              s1_end;

  // frame state
  logic              seeded, seeded_next;
  logic [BYTE_W-1:0] expected, expected_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic              frame_seq_err, frame_seq_err_next;
  logic              frame_payload_err, frame_payload_err_next;
  logic              skip_rest, skip_rest_next;
  logic [BYTE_W-1:0] first_byte, first_byte_next;
  logic [POS_W-1:0]  first_bad_position, first_bad_position_next;
  logic              sticky_failure, sticky_failure_next;
  logic              in_frame, in_frame_next;
  logic              past_end, past_end_next;
  logic [BYTE_W-1:0] check_expected, check_expected_next;

  logic              byte_take;
  logic              s1_go;
  logic              emit;
  logic [BYTE_W-1:0] seed_exp;
  logic [POS_W:0]    pos;

  // Handshake: the byte register drains whenever the status register is free.
  assign byte_take  = byte_valid && !byte_stall;
  assign s1_go      = s1_valid && !(status_valid && status_stall);
  assign byte_stall = s1_valid && status_valid && status_stall;
  assign seed_exp   = seeded ? expected : s1_data;
  assign pos        = {1'b0, byte_position} + (POS_W + 1)'(1);

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerant_mode  <= 1'b0;
      verify_payload <= 1'b0;
      stop_on_error  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOLERANT_MODE:  tolerant_mode  <= cfg_data;
        REG_VERIFY_PAYLOAD: verify_payload <= cfg_data;
        REG_STOP_ON_ERROR:  stop_on_error  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture incoming byte requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      s1_data  <= data_byte;
      s1_start <= frame_start;
      s1_end   <= frame_end;
    end
  end

  // Advance frame state for the registered byte.
  always_comb begin
    seeded_next             = seeded;
    expected_next           = expected;
    byte_position_next      = byte_position;
    frame_seq_err_next      = frame_seq_err;
    frame_payload_err_next  = frame_payload_err;
    skip_rest_next          = skip_rest;
    first_byte_next         = first_byte;
    first_bad_position_next = first_bad_position;
    sticky_failure_next     = sticky_failure;
    in_frame_next           = in_frame;
    past_end_next           = past_end;
    check_expected_next     = check_expected;
    emit                    = 1'b0;

    if (s1_go) begin
      if (s1_start) begin
        in_frame_next           = 1'b1;
        byte_position_next      = '0;
        frame_seq_err_next      = 1'b0;
        frame_payload_err_next  = 1'b0;
        skip_rest_next          = 1'b0;
        past_end_next           = 1'b0;
        first_bad_position_next = '0;
        first_byte_next         = s1_data;
        seeded_next             = 1'b1;
        // tolerant mode takes a one-ahead sequence as the new expectation
        if (tolerant_mode && (s1_data == seed_exp + BYTE_W'(1))) begin
          expected_next = s1_data;
        end else begin
          expected_next = seed_exp;
        end
        check_expected_next = expected_next;
        if (s1_data != expected_next) begin
          frame_seq_err_next = 1'b1;
          if (stop_on_error) begin
            sticky_failure_next = 1'b1;
            skip_rest_next      = 1'b1;
          end else begin
            expected_next = s1_data;
          end
        end
      end else if (in_frame && !skip_rest && !past_end) begin
        if (pos >= MAX_POS) begin
          past_end_next = 1'b1;
        end else begin
          byte_position_next = pos[POS_W-1:0];
          if (verify_payload && !frame_payload_err && (s1_data != '0) &&
              (s1_data != expected + BYTE_W'(pos))) begin
            frame_payload_err_next  = 1'b1;
            first_bad_position_next = pos[POS_W-1:0];
            if (stop_on_error) begin
              sticky_failure_next = 1'b1;
              skip_rest_next      = 1'b1;
            end
          end
        end
      end

      // Close the frame and issue its status.
      if ((s1_start || in_frame) && s1_end) begin
        emit          = 1'b1;
        in_frame_next = 1'b0;
        if (!tolerant_mode && !skip_rest_next) begin
          expected_next = expected_next + BYTE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded             <= 1'b0;
      expected           <= '0;
      byte_position      <= '0;
      frame_seq_err      <= 1'b0;
      frame_payload_err  <= 1'b0;
      skip_rest          <= 1'b0;
      first_byte         <= '0;
      first_bad_position <= '0;
      sticky_failure     <= 1'b0;
      in_frame           <= 1'b0;
      past_end           <= 1'b0;
      check_expected     <= '0;
    end else begin
      seeded             <= seeded_next;
      expected           <= expected_next;
      byte_position      <= byte_position_next;
      frame_seq_err      <= frame_seq_err_next;
      frame_payload_err  <= frame_payload_err_next;
      skip_rest          <= skip_rest_next;
      first_byte         <= first_byte_next;
      first_bad_position <= first_bad_position_next;
      sticky_failure     <= sticky_failure_next;
      in_frame           <= in_frame_next;
      past_end           <= past_end_next;
      check_expected     <= check_expected_next;
    end
  end

  // Hold or load the status register.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (emit) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seq_mismatch     <= frame_seq_err_next;
      payload_mismatch <= frame_payload_err_next;
      expected_seq     <= check_expected_next;
      got_seq          <= first_byte_next;
      bad_position     <= first_bad_position_next;
      failed           <= sticky_failure_next;
    end
  end

  // Checks on internal behavior.
  `LSC_ASSERT_NEXT(a_failure_sticky, clk, rst, sticky_failure, sticky_failure)
  `LSC_ASSERT_IMPLY(a_bad_pos_set, clk, rst, status_valid && payload_mismatch,
                    bad_position != '0)
  `LSC_ASSERT_IMPLY(a_bad_pos_clear, clk, rst, status_valid && !payload_mismatch,
                    bad_position == '0)
  `LSC_ASSERT_IMPLY(a_emit_only_free, clk, rst, emit,
                    !(status_valid && status_stall))

endmodule

// ===== verif/lsc_tb_pkg.sv =====
`timescale 1ns / 1ps

package lsc_tb_pkg;
  import lsc_pkg::*;

  localparam int FRAME_BYTES_MAX = 64;

  // One frame status request as seen on the status channel
  typedef struct packed {
    logic                seq_mismatch;
    logic                payload_mismatch;
    logic [BYTE_W-1:0]   expected_seq;
    logic [BYTE_W-1:0]   got_seq;
    logic [POS_W-1:0]    bad_position;
    logic                failed;
  } frame_status_t;

  class frame_status_board;
    // mode bits
    logic tolerant, verify, stop;
    // sequence tracking
    logic [BYTE_W-1:0] seq_expect, seq_checked, first_seen;
    logic [POS_W-1:0]  byte_pos, first_bad;
    logic seeded, in_frame, past_end, skip_rest, seq_err, pay_err, sticky;
    frame_status_t status_q[$];
    int n_errors, n_status, n_seq_err, n_pay_err, n_failed;

    function new();
      tolerant = 0; verify = 0; stop = 0;
      seq_expect = '0; seq_checked = '0; first_seen = '0;
      byte_pos = '0; first_bad = '0;
      seeded = 0; in_frame = 0; past_end = 0; skip_rest = 0;
      seq_err = 0; pay_err = 0; sticky = 0;
      n_errors = 0; n_status = 0; n_seq_err = 0; n_pay_err = 0; n_failed = 0;
    endfunction

    function void set_mode(cfg_reg_t idx, logic v);
      case (idx)
        REG_TOLERANT_MODE:  tolerant = v;
        REG_VERIFY_PAYLOAD: verify = v;
        REG_STOP_ON_ERROR:  stop = v;
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] next_seq();
      return seq_expect;
    endfunction

    function bit frame_open();
      return in_frame;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Update the frame state for one accepted byte request
    function void note_byte(logic [BYTE_W-1:0] d, logic s, logic e);
      frame_status_t st;
      int pos;
      if (s) begin
        in_frame = 1; byte_pos = '0; seq_err = 0; pay_err = 0;
        skip_rest = 0; past_end = 0; first_bad = '0; first_seen = d;
        if (!seeded) begin
          seq_expect = d;
          seeded = 1;
        end
        // tolerant mode accepts the next number and moves up to it
        if (tolerant && d == seq_expect + 8'd1) seq_expect = d;
        seq_checked = seq_expect;
        if (d != seq_expect) begin
          seq_err = 1;
          if (stop) begin
            sticky = 1;
            skip_rest = 1;
          end else begin
            seq_expect = d;
          end
        end
      end else begin
        // drop bytes outside a frame
        if (!in_frame) return;
        if (!skip_rest && !past_end) begin
          pos = int'(byte_pos) + 1;
          if (pos >= FRAME_BYTES_MAX) begin
            past_end = 1;
          end else begin
            byte_pos = pos[POS_W-1:0];
            if (verify && !pay_err && d != 8'd0 && d != 8'(int'(seq_expect) + pos)) begin
              pay_err = 1;
              first_bad = pos[POS_W-1:0];
              if (stop) begin
                sticky = 1;
                skip_rest = 1;
              end
            end
          end
        end
      end
      if (!e) return;
      st.seq_mismatch = seq_err;
      st.payload_mismatch = pay_err;
      st.expected_seq = seq_checked;
      st.got_seq = first_seen;
      st.bad_position = first_bad;
      st.failed = sticky;
      status_q.push_back(st);
      if (!tolerant && !skip_rest) seq_expect = seq_expect + 8'd1;
      in_frame = 0;
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        n_errors++;
      end
    endfunction

    // Compare one accepted status request with the oldest prediction
    function void check_status(frame_status_t got);
      frame_status_t exp_st;
      if (status_q.size() == 0) begin
        $error("status request with no frame end pending");
        n_errors++;
        return;
      end
      exp_st = status_q.pop_front();
      n_status++;
      if (exp_st.seq_mismatch) n_seq_err++;
      if (exp_st.payload_mismatch) n_pay_err++;
      if (exp_st.failed) n_failed++;
      cmp_field("seq_mismatch", 8'(exp_st.seq_mismatch), 8'(got.seq_mismatch));
      cmp_field("payload_mismatch", 8'(exp_st.payload_mismatch), 8'(got.payload_mismatch));
      cmp_field("expected_seq", exp_st.expected_seq, got.expected_seq);
      cmp_field("got_seq", exp_st.got_seq, got.got_seq);
      cmp_field("bad_position", 8'(exp_st.bad_position), 8'(got.bad_position));
      cmp_field("failed", 8'(exp_st.failed), 8'(got.failed));
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lsc_pkg::*;
  import lsc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic              cfg_data;
  logic              byte_valid;
  logic              byte_stall;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;
  logic              frame_end;
  logic              status_valid;
  logic              status_stall;
  logic              seq_mismatch;
  logic              payload_mismatch;
  logic [BYTE_W-1:0] expected_seq;
  logic [BYTE_W-1:0] got_seq;
  logic [POS_W-1:0]  bad_position;
  logic              failed;

  frame_status_board sb;
  bit idle_on = 1'b1;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int frame_bytes = 0;

  link_sequence_checker i_dut (.*);

  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Take status requests and drive the stall side
  always @(posedge clk) begin
    if (!rst && status_valid && !status_stall)
      sb.check_status('{seq_mismatch, payload_mismatch, expected_seq, got_seq,
                        bad_position, failed});
    if (rst) begin
      status_stall <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      status_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      status_stall <= 1'b1;
    end else begin
      status_stall <= idle_on && ($urandom_range(99) < 29);
    end
  end

  // Offer one byte request and wait until it is taken
  task automatic send_byte(input logic [7:0] d, input logic s, input logic e);
    int gaps;
    gaps = 0;
    while (idle_on && $urandom_range(99) < 29) gaps++;
    if (gaps > 0) begin
      byte_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    frame_start <= s;
    frame_end <= e;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(d, s, e);
    bytes_sent++;
  endtask

  // Write all three mode registers back to back
  task automatic apply_mode(input logic t, input logic v, input logic s);
    cfg_write <= 1'b1;
    cfg_index <= REG_TOLERANT_MODE;
    cfg_data <= t;
    sb.set_mode(REG_TOLERANT_MODE, t);
    @(posedge clk);
    cfg_index <= REG_VERIFY_PAYLOAD;
    cfg_data <= v;
    sb.set_mode(REG_VERIFY_PAYLOAD, v);
    @(posedge clk);
    cfg_index <= REG_STOP_ON_ERROR;
    cfg_data <= s;
    sb.set_mode(REG_STOP_ON_ERROR, s);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stop offering, wait for every status and let the pipeline settle
  task automatic drain();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Send one random frame, or a few stray bytes outside any frame
  task automatic send_frame();
    int len, base, c;
    logic [7:0] first, d;
    logic s;
    c = $urandom_range(99);
    if (c < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      return;
    end
    len = ($urandom_range(99) < 5) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    c = $urandom_range(99);
    first = sb.next_seq();
    if (c >= 85) first = 8'($urandom);
    else if (c >= 70) first = first + 8'd1;
    base = 0;
    for (int i = 0; i < len; i++) begin
      s = (i == 0);
      d = first;
      if (i > 0) begin
        c = $urandom_range(99);
        if (c < 3) begin
          // restart the frame mid-way
          s = 1'b1;
          base = i;
          first = sb.next_seq();
          d = first;
        end else if (c < 85) begin
          d = 8'(int'(first) + i - base);
        end else if (c < 92) begin
          d = 8'h00;
        end else begin
          d = 8'($urandom);
        end
      end
      send_byte(d, s, i == len - 1);
      frame_bytes++;
    end
  endtask

  task automatic run_phase(input int n, input bit squeeze);
    int start;
    bit squeezed;
    start = frame_bytes;
    squeezed = 0;
    while (frame_bytes - start < n) begin
      send_frame();
      if (squeeze && !squeezed && frame_bytes - start > 20) begin
        hold_asks++;
        squeezed = 1;
      end
    end
    // close an open frame before the modes change
    if (sb.frame_open()) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_TOLERANT_MODE;
    cfg_data <= 1'b0;
    byte_valid <= 1'b0;
    data_byte <= '0;
    frame_start <= 1'b0;
    frame_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: strict mode with payload checks
    apply_mode(1'b0, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);   // stray byte before any frame
    send_byte(8'hFF, 1'b1, 1'b1);   // seed, one-byte frame, wraps to 00
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);   // zero byte is not checked
    send_byte(8'hAA, 1'b0, 1'b1);   // bad payload at position 3
    send_byte(8'h80, 1'b1, 1'b0);   // sequence error, resync
    send_byte(8'h81, 1'b0, 1'b1);
    send_byte(8'h81, 1'b1, 1'b0);
    send_byte(8'h82, 1'b0, 1'b0);
    send_byte(8'h81, 1'b1, 1'b1);   // restart abandons the open frame
    send_byte(8'h82, 1'b1, 1'b0);
    send_byte(8'h83, 1'b0, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);   // first payload error
    send_byte(8'h22, 1'b0, 1'b1);   // second one is ignored
    drain();

    // Directed: tolerant mode
    apply_mode(1'b1, 1'b1, 1'b0);
    send_byte(8'h84, 1'b1, 1'b1);   // one ahead, accepted
    send_byte(8'h84, 1'b1, 1'b1);   // no auto increment
    send_byte(8'h86, 1'b1, 1'b0);   // two ahead, mismatch
    send_byte(8'h87, 1'b0, 1'b1);
    drain();

    // Random: walk every mode setting, stop on error last
    for (int p = 0; p < 8; p++) begin
      apply_mode(p[0], p[1], p[2]);
      idle_on = (p != 2);
      run_phase(137, p == 3);
      drain();
    end
    idle_on = 1'b1;
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes; checked %0d frame statuses over all 8 mode settings",
             bytes_sent, sb.n_status);
    $display("Statuses with sequence error %0d, payload error %0d, sticky failure %0d",
             sb.n_seq_err, sb.n_pay_err, sb.n_failed);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lsc_pkg.sv
hdl/link_sequence_checker.sv
verif/lsc_tb_pkg.sv
verif/tb_top.sv
